// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the reconnect controller checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`endif

// ===== sv/lrbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrbc_pkg
// Types, codes and reset constants of the link reconnect backoff controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lrbc_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int RETRY_WIDTH_DEF = 8;

  localparam int BACKOFF_W   = 16;
  localparam int SHIFT_W     = $clog2(BACKOFF_W);
  localparam int MAX_RETRY_W = 8;
  localparam int RETRIES_W   = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RETRY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_BASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_CAP    = 3'd3;

  localparam logic                   AUTO_RETRY_RST     = 1'b1;
  localparam logic [MAX_RETRY_W-1:0] MAX_RETRIES_RST    = 8'd10;
  localparam logic [BACKOFF_W-1:0]   BACKOFF_BASE_RST   = 16'd1000;
  localparam logic [BACKOFF_W-1:0]   BACKOFF_CAP_RST    = 16'd32000;

  typedef enum logic [2:0] {
    MODE_TICK            = 3'd0,
    MODE_CONNECTING      = 3'd1,
    MODE_CONNECTED       = 3'd2,
    MODE_GOT_IP          = 3'd3,
    MODE_LINK_LOST       = 3'd4,
    MODE_TRIGGER         = 3'd5,
    MODE_USER_CONNECT    = 3'd6,
    MODE_USER_DISCONNECT = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    LINK_DOWN       = 2'd0,
    LINK_CONNECTING = 2'd1,
    LINK_CONNECTED  = 2'd2,
    LINK_GOT_IP     = 2'd3
  } link_e;

  typedef struct packed {
    logic                   auto_retry;
    logic [MAX_RETRY_W-1:0] max_retries;
    logic [BACKOFF_W-1:0]   backoff_base;
    logic [BACKOFF_W-1:0]   backoff_cap;
  } cfg_t;

  typedef struct packed {
    mode_e mode;
    logic  saved_found;
  } in_t;

  typedef struct packed {
    link_e                link_status;
    logic                 status_changed;
    logic                 reconnect_request;
    logic                 exhausted_now;
    logic                 limit_reached;
    logic [RETRIES_W-1:0] retries_done;
    logic                 retry_armed;
  } out_t;

endpackage

`default_nettype wire

// ===== sv/lrbc_backoff.sv =====
// ----------------------------------------------------------------------------
// lrbc_backoff
// Backoff delay: base shifted left by (retry - 1), capped, fit to the timer.
// ----------------------------------------------------------------------------
`default_nettype none

module lrbc_backoff #(
  parameter int TIMER_WIDTH = lrbc_pkg::TIMER_WIDTH_DEF,
  parameter int RETRY_WIDTH = lrbc_pkg::RETRY_WIDTH_DEF
) (
  input  lrbc_pkg::cfg_t          cfg_i,
  input  logic [RETRY_WIDTH-1:0]  retry_count_i,
  output logic [TIMER_WIDTH-1:0]  delay_o
);
  import lrbc_pkg::*;

  localparam int CW = (TIMER_WIDTH > BACKOFF_W) ? TIMER_WIDTH : BACKOFF_W;
  localparam logic [CW-1:0] TIMER_MAX_EXT = CW'({TIMER_WIDTH{1'b1}});

  logic [RETRY_WIDTH-1:0]   shift;
  logic [2*BACKOFF_W-1:0]   shifted;
  logic [BACKOFF_W-1:0]     capped;
  logic [CW-1:0]            capped_ext;

  // The count is at least one whenever a delay is armed.
  assign shift   = retry_count_i - RETRY_WIDTH'(1);
  assign shifted = {{BACKOFF_W{1'b0}}, cfg_i.backoff_base} << shift[SHIFT_W-1:0];

  // A nonzero base shifted by the full word width or more is always above the cap.
  always_comb begin
    if (cfg_i.backoff_base == '0) begin
      capped = '0;
    end else if (32'(shift) >= 32'(BACKOFF_W)) begin
      capped = cfg_i.backoff_cap;
    end else if (shifted > {{BACKOFF_W{1'b0}}, cfg_i.backoff_cap}) begin
      capped = cfg_i.backoff_cap;
    end else begin
      capped = shifted[BACKOFF_W-1:0];
    end
  end

  assign capped_ext = CW'(capped);
  assign delay_o    = TIMER_WIDTH'((capped_ext > TIMER_MAX_EXT) ? TIMER_MAX_EXT : capped_ext);

endmodule

`default_nettype wire

// ===== sv/link_reconnect_backoff_controller.sv =====
// ----------------------------------------------------------------------------
// link_reconnect_backoff_controller
// Link state tracker with exponential-backoff reconnect scheduling.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the input channel (in_valid_i / in_ready_o / in_i) is one
// time tick, link event or user command. Every request yields exactly one
// result on the output channel (out_valid_o / out_ready_i / out_o) carrying
// the link status, the reconnect and exhausted pulses, the sticky limit flag,
// the retry count and the armed flag, all taken after the update.
// The edge that accepts a request loads the input register, and the edge
// at which it moves on writes the state and the result register.
// Throughput is one request per cycle while results are taken; the state
// update of one request is a single pass of logic between the input
// register and the result register, the widest piece being the backoff
// shift and cap compare. The input register accepts a new request while a
// result still waits, so a stalled receiver only holds the pipe once both
// registers are full; ready then drops and nothing is lost or repeated.
// Reset clears the link state, retry state, timer and both valid flags and
// loads the configuration defaults. Configuration writes (cfg_we_i) take
// effect at once and are meant to be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module link_reconnect_backoff_controller #(
  parameter int TIMER_WIDTH = lrbc_pkg::TIMER_WIDTH_DEF,
  parameter int RETRY_WIDTH = lrbc_pkg::RETRY_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lrbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lrbc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lrbc_pkg::in_t                   in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lrbc_pkg::out_t                  out_o
);
  import lrbc_pkg::*;

  localparam int CMP_W = (RETRY_WIDTH > MAX_RETRY_W) ? RETRY_WIDTH : MAX_RETRY_W;
  localparam int OUT_W = (CMP_W > RETRIES_W) ? CMP_W : RETRIES_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
  localparam logic [RETRY_WIDTH-1:0] RETRY_MAX = '1;

  // Configuration registers.
  cfg_t cfg_q;

  // Pipeline registers.
  in_t  req_q;
  logic req_valid_q;
  out_t out_q, out_d;
  logic out_valid_q;

  // Controller state.
  link_e                  link_q, link_d;
  logic [RETRY_WIDTH-1:0] retry_q, retry_d;
  logic                   limit_q, limit_d;
  logic                   armed_q, armed_d;
  logic [TIMER_WIDTH-1:0] wait_q, wait_d;
  logic [TIMER_WIDTH-1:0] elapsed_q, elapsed_d;
  logic                   cred_q, cred_d;

  logic                   out_free;
  logic                   fire;
  logic                   in_accept;
  logic [TIMER_WIDTH-1:0] elapsed_inc;
  logic [RETRY_WIDTH-1:0] retry_inc;
  logic                   retry_hit;
  logic [TIMER_WIDTH-1:0] backoff_delay;
  logic                   request;
  logic                   exhausted;
  logic [OUT_W-1:0]       retry_ext;

  // The result register frees up when empty or when its result is taken,
  // and the held request is processed exactly when it can move there.
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = req_valid_q && out_free;
  assign in_ready_o = !req_valid_q || out_free;
  assign in_accept  = in_valid_i && in_ready_o;

  // Configuration writes; indexes beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_retry     <= AUTO_RETRY_RST;
      cfg_q.max_retries    <= MAX_RETRIES_RST;
      cfg_q.backoff_base   <= BACKOFF_BASE_RST;
      cfg_q.backoff_cap    <= BACKOFF_CAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AUTO_RETRY:     cfg_q.auto_retry     <= cfg_data_i[0];
        CFG_MAX_RETRIES:    cfg_q.max_retries    <= cfg_data_i[MAX_RETRY_W-1:0];
        CFG_BACKOFF_BASE:   cfg_q.backoff_base   <= cfg_data_i[BACKOFF_W-1:0];
        CFG_BACKOFF_CAP:    cfg_q.backoff_cap    <= cfg_data_i[BACKOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturating counters and the retry limit compare.
  assign elapsed_inc = (elapsed_q != TIMER_MAX) ? elapsed_q + TIMER_WIDTH'(1) : elapsed_q;
  assign retry_inc   = (retry_q != RETRY_MAX) ? retry_q + RETRY_WIDTH'(1) : retry_q;
  assign retry_hit   = CMP_W'(retry_inc) >= CMP_W'(cfg_q.max_retries);

  lrbc_backoff #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .RETRY_WIDTH (RETRY_WIDTH)
  ) u_backoff (
    .cfg_i         (cfg_q),
    .retry_count_i (retry_inc),
    .delay_o       (backoff_delay)
  );

  // Next state for the request held in the input register.
  always_comb begin
    link_d    = link_q;
    retry_d   = retry_q;
    limit_d   = limit_q;
    armed_d   = armed_q;
    wait_d    = wait_q;
    elapsed_d = elapsed_q;
    cred_d    = cred_q;
    request   = 1'b0;
    exhausted = 1'b0;
    case (req_q.mode)
      MODE_TICK: begin
        // Only an armed timer advances; it fires once the delay is covered.
        if (armed_q) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= wait_q) begin
            armed_d = 1'b0;
            request = 1'b1;
          end
        end
      end
      MODE_CONNECTING: begin
        link_d = LINK_CONNECTING;
      end
      MODE_CONNECTED: begin
        retry_d = '0;
        limit_d = 1'b0;
        armed_d = 1'b0;
        link_d  = LINK_CONNECTED;
      end
      MODE_GOT_IP: begin
        retry_d = '0;
        limit_d = 1'b0;
        armed_d = 1'b0;
        link_d  = LINK_GOT_IP;
      end
      MODE_LINK_LOST: begin
        if (cfg_q.auto_retry && cred_q) begin
          retry_d = retry_inc;
          if (retry_hit) begin
            limit_d   = 1'b1;
            armed_d   = 1'b0;
            exhausted = 1'b1;
          end else begin
            wait_d    = backoff_delay;
            elapsed_d = '0;
            armed_d   = 1'b1;
          end
        end
        link_d = LINK_DOWN;
      end
      MODE_TRIGGER: begin
        // Immediate reconnect that also restarts the retry sequence.
        if (req_q.saved_found) begin
          cred_d    = 1'b1;
          retry_d   = '0;
          limit_d   = 1'b0;
          armed_d   = 1'b0;
          wait_d    = '0;
          elapsed_d = '0;
          request   = 1'b1;
        end
      end
      MODE_USER_CONNECT: begin
        if (req_q.saved_found) begin
          cred_d  = 1'b1;
          request = 1'b1;
        end
      end
      MODE_USER_DISCONNECT: begin
        armed_d = 1'b0;
      end
      default: begin
        armed_d = 1'b0;
      end
    endcase
  end

  assign retry_ext = OUT_W'(retry_d);

  always_comb begin
    out_d.link_status       = link_d;
    out_d.status_changed    = (link_d != link_q);
    out_d.reconnect_request = request;
    out_d.exhausted_now     = exhausted;
    out_d.limit_reached     = limit_d;
    out_d.retries_done      = retry_ext[RETRIES_W-1:0];
    out_d.retry_armed       = armed_d;
  end

  // Valid flags and controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      link_q      <= LINK_DOWN;
      retry_q     <= '0;
      limit_q     <= 1'b0;
      armed_q     <= 1'b0;
      wait_q      <= '0;
      elapsed_q   <= '0;
      cred_q      <= 1'b0;
    end else begin
      if (in_accept) begin
        req_valid_q <= 1'b1;
      end else if (fire) begin
        req_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        link_q    <= link_d;
        retry_q   <= retry_d;
        limit_q   <= limit_d;
        armed_q   <= armed_d;
        wait_q    <= wait_d;
        elapsed_q <= elapsed_d;
        cred_q    <= cred_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== sv/lrbc_checker.sv =====
// ----------------------------------------------------------------------------
// lrbc_checker
// Port-level checks of the reconnect controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lrbc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [lrbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [lrbc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input lrbc_pkg::in_t                   in_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input lrbc_pkg::out_t                  out_o
);
  import lrbc_pkg::*;

  logic exh_seen;
  logic exh_state_ok;
  logic unused_cfg;

  assign exh_seen     = out_valid_o && out_o.exhausted_now;
  assign exh_state_ok = out_o.limit_reached && !out_o.retry_armed &&
                        !out_o.reconnect_request && (out_o.link_status == LINK_DOWN);
  assign unused_cfg   = cfg_we_i ^ (^cfg_idx_i) ^ (^cfg_data_i) ^ in_valid_i ^ in_ready_o ^
                        (^in_i);

  // A result that reaches the limit leaves the link down with nothing scheduled.
  `ASSERT_PROP(a_exhausted_state, clk_i, rst_ni, exh_seen |-> exh_state_ok, "exhausted state")

  // A reconnect request and an exhaustion never come from the same request.
  `ASSERT_NEVER(a_req_vs_exh, clk_i, rst_ni,
                out_valid_o && out_o.reconnect_request && out_o.exhausted_now,
                "request and exhausted together")

  // A result held by the receiver stays put until it is taken.
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni,
               (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_o)),
               "stalled result changed")

endmodule

bind link_reconnect_backoff_controller lrbc_checker u_lrbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

`default_nettype wire

// ===== verif/reconnect_checker_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reconnect_checker_pkg
// Holds a cycle-free copy of the reconnect controller's link, retry and
// backoff state. It predicts the status of each accepted request and checks
// the results of the block against those predictions in order.
// ----------------------------------------------------------------------------
package reconnect_checker_pkg;

  import lrbc_pkg::*;

  class reconnect_checker;

    // Local copy of the configuration registers.
    logic                   auto_on;
    logic [MAX_RETRY_W-1:0] retry_limit;
    logic [BACKOFF_W-1:0]   base_delay;
    logic [BACKOFF_W-1:0]   cap_delay;

    // Local copy of the link and retry state.
    link_e                        link_q;
    logic [RETRY_WIDTH_DEF-1:0]   retries;
    logic                         limit_hit;
    logic                         armed;
    logic                         creds;
    logic [TIMER_WIDTH_DEF-1:0]   wait_ticks;
    logic [TIMER_WIDTH_DEF-1:0]   elapsed;

    out_t        pending_status[$];
    int unsigned num_requests;
    int unsigned num_results;
    int unsigned num_errors;
    int unsigned num_reconnects;
    int unsigned num_exhausted;

    function new();
      auto_on        = AUTO_RETRY_RST;
      retry_limit    = MAX_RETRIES_RST;
      base_delay     = BACKOFF_BASE_RST;
      cap_delay      = BACKOFF_CAP_RST;
      link_q         = LINK_DOWN;
      retries        = '0;
      limit_hit      = 1'b0;
      armed          = 1'b0;
      creds          = 1'b0;
      wait_ticks     = '0;
      elapsed        = '0;
      num_requests   = 0;
      num_results    = 0;
      num_errors     = 0;
      num_reconnects = 0;
      num_exhausted  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_AUTO_RETRY:     auto_on     = data[0];
        CFG_MAX_RETRIES:    retry_limit = data[MAX_RETRY_W-1:0];
        CFG_BACKOFF_BASE:   base_delay  = data[BACKOFF_W-1:0];
        CFG_BACKOFF_CAP:    cap_delay   = data[BACKOFF_W-1:0];
        default: ;
      endcase
    endfunction

    // Advances the state by one request and queues the status it yields.
    function void note_request(in_t req);
      out_t        res;
      link_e       prior;
      logic        fire;
      logic        exh;
      logic [63:0] wide;
      int unsigned shift;
      prior = link_q;
      fire  = 1'b0;
      exh   = 1'b0;
      case (req.mode)
        MODE_TICK: begin
          if (armed) begin
            if (elapsed != '1) elapsed = elapsed + TIMER_WIDTH_DEF'(1);
            if (elapsed >= wait_ticks) begin
              armed = 1'b0;
              fire  = 1'b1;
            end
          end
        end
        MODE_CONNECTING: link_q = LINK_CONNECTING;
        MODE_CONNECTED, MODE_GOT_IP: begin
          retries   = '0;
          limit_hit = 1'b0;
          armed     = 1'b0;
          link_q    = (req.mode == MODE_CONNECTED) ? LINK_CONNECTED : LINK_GOT_IP;
        end
        MODE_LINK_LOST: begin
          if (auto_on && creds) begin
            if (retries != '1) retries = retries + RETRY_WIDTH_DEF'(1);
            if (retries >= retry_limit) begin
              limit_hit = 1'b1;
              armed     = 1'b0;
              exh       = 1'b1;
            end else begin
              // Doubling backoff; huge shifts go straight to the cap.
              shift = 32'(retries) - 32'd1;
              if (base_delay == '0) wide = '0;
              else if (shift >= 40) wide = 64'(cap_delay);
              else begin
                wide = 64'(base_delay) << shift;
                if (wide > 64'(cap_delay)) wide = 64'(cap_delay);
              end
              wait_ticks = wide[TIMER_WIDTH_DEF-1:0];
              elapsed    = '0;
              armed      = 1'b1;
            end
          end
          link_q = LINK_DOWN;
        end
        MODE_TRIGGER: begin
          if (req.saved_found) begin
            creds      = 1'b1;
            retries    = '0;
            limit_hit  = 1'b0;
            armed      = 1'b0;
            wait_ticks = '0;
            elapsed    = '0;
            fire       = 1'b1;
          end
        end
        MODE_USER_CONNECT: begin
          if (req.saved_found) begin
            creds = 1'b1;
            fire  = 1'b1;
          end
        end
        MODE_USER_DISCONNECT: armed = 1'b0;
        default: ;
      endcase
      res.link_status       = link_q;
      res.status_changed    = (link_q != prior);
      res.reconnect_request = fire;
      res.exhausted_now     = exh;
      res.limit_reached     = limit_hit;
      res.retries_done      = retries[RETRIES_W-1:0];
      res.retry_armed       = armed;
      pending_status.push_back(res);
      num_requests++;
    endfunction

    function void report_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        num_errors++;
        $error("result %0d field %s: expected %0d, actual %0d",
               num_results, name, exp_v, act_v);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_status.size() == 0) begin
        num_errors++;
        $error("result %0d arrived with no request outstanding", num_results);
      end else begin
        want = pending_status.pop_front();
        report_field("link_status", want.link_status, got.link_status);
        report_field("status_changed", want.status_changed, got.status_changed);
        report_field("reconnect_request", want.reconnect_request, got.reconnect_request);
        report_field("exhausted_now", want.exhausted_now, got.exhausted_now);
        report_field("limit_reached", want.limit_reached, got.limit_reached);
        report_field("retries_done", want.retries_done, got.retries_done);
        report_field("retry_armed", want.retry_armed, got.retry_armed);
        if (want.reconnect_request) num_reconnects++;
        if (want.exhausted_now) num_exhausted++;
      end
      num_results++;
    endfunction

    function int unsigned pending();
      return pending_status.size();
    endfunction

  endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the link reconnect backoff controller. A short
// directed sequence walks the link events, commands and corner cases, then
// random reconnect rounds run under a series of register settings while both
// channels idle at random and the receiver stalls long enough to back the
// block up. Every result is checked against a predicted status.
// ----------------------------------------------------------------------------
module tb_top;

  import lrbc_pkg::*;
  import reconnect_checker_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 11;
  // Requests between these counts see no random idling on either side.
  localparam int CALM_FIRST  = 900;
  localparam int CALM_LAST   = 1300;
  localparam int HOLD_CYCLES = 80;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;

  reconnect_checker chk = new();

  int unsigned cycles = 0;
  int unsigned n_settings = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold = 500;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  link_reconnect_backoff_controller i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  // A window mid-run where neither side idles at random, so the block
  // sees back-to-back traffic for a long stretch.
  function automatic logic calm();
    return (chk.num_requests >= CALM_FIRST) && (chk.num_requests < CALM_LAST);
  endfunction

  // Watchdog: the whole run must finish well inside the cycle budget.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver side. The result is checked when valid and ready meet at the
  // edge; both are sampled before this edge's updates take effect. Twice in
  // the run the receiver holds ready low for a long stretch, counted here,
  // so the pipe fills up and the block pushes back on its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) chk.check_result(out_data);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (chk.num_results >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold = next_hold + 1100;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm() || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Offers one request, idling first at random, and returns at the edge
  // where it is accepted. Valid stays high into the next request unless an
  // idle gap follows.
  task automatic send_request(input mode_e mode, input logic found);
    in_t req;
    req.mode        = mode;
    req.saved_found = found;
    while (!calm() && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chk.note_request(req);
  endtask

  // Waits until every request has produced its result, then lets the
  // pipe run dry before anything touches the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    chk.write_reg(idx, data);
  endtask

  // Loads all four registers while the block is idle. The upper data bits
  // carry junk to show the block masks them. With junk set, the indexes
  // past the last register are written too and must have no effect.
  task automatic configure(input logic auto_on, input logic [MAX_RETRY_W-1:0] limit,
                           input logic [BACKOFF_W-1:0] base,
                           input logic [BACKOFF_W-1:0] cap, input logic junk);
    settle();
    write_reg(CFG_AUTO_RETRY, {15'($urandom), auto_on});
    write_reg(CFG_MAX_RETRIES, {8'($urandom), limit});
    write_reg(CFG_BACKOFF_BASE, base);
    write_reg(CFG_BACKOFF_CAP, cap);
    if (junk) begin
      for (int j = 0; j < 4; j++)
        write_reg(CFG_IDX_W'(CFG_BACKOFF_CAP + 1 + j), CFG_DATA_W'($urandom));
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Credentials in hand, then a long run of link losses with no success in
  // between, to drive the retry count into its limit and its saturation.
  task automatic loss_burst(input int count);
    send_request(MODE_TRIGGER, 1'b1);
    repeat (count) send_request(MODE_LINK_LOST, 1'($urandom_range(0, 1)));
  endtask

  // Mostly whole reconnect rounds: the link drops, the backoff timer gets
  // some ticks, and the link may come back. The rest is any request at all.
  task automatic run_random(input int count);
    int sent;
    int ticks;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 80) begin
        send_request(MODE_LINK_LOST, 1'($urandom_range(0, 1)));
        sent++;
        ticks = $urandom_range(0, 12);
        repeat (ticks) send_request(MODE_TICK, 1'($urandom_range(0, 1)));
        sent += ticks;
        if ($urandom_range(0, 1)) begin
          send_request(MODE_CONNECTING, 1'($urandom_range(0, 1)));
          sent++;
        end
        if ($urandom_range(0, 99) < 35) begin
          send_request($urandom_range(0, 1) ? MODE_CONNECTED : MODE_GOT_IP,
                       1'($urandom_range(0, 1)));
          sent++;
        end
      end else begin
        send_request(mode_e'($urandom_range(0, 7)), $urandom_range(0, 3) != 0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings. No credentials are known yet,
    // so link losses only move the link to disconnected, and a trigger or
    // user connect without credentials is ignored.
    send_request(MODE_TICK, 1'b1);
    send_request(MODE_LINK_LOST, 1'b1);
    send_request(MODE_CONNECTING, 1'b0);
    send_request(MODE_LINK_LOST, 1'b0);
    send_request(MODE_TRIGGER, 1'b0);
    send_request(MODE_USER_CONNECT, 1'b0);
    // User connect with credentials pulses a reconnect, retry state unchanged.
    send_request(MODE_USER_CONNECT, 1'b1);
    send_request(MODE_CONNECTED, 1'b0);
    send_request(MODE_LINK_LOST, 1'b0);
    send_request(MODE_TICK, 1'b0);
    // User disconnect drops the armed reconnect but leaves the link alone.
    send_request(MODE_USER_DISCONNECT, 1'b1);
    send_request(MODE_TICK, 1'b0);
    send_request(MODE_LINK_LOST, 1'b0);
    send_request(MODE_GOT_IP, 1'b1);
    send_request(MODE_LINK_LOST, 1'b0);
    // Trigger with credentials clears the retry state and pulses at once.
    send_request(MODE_TRIGGER, 1'b1);
    send_request(MODE_USER_DISCONNECT, 1'b0);

    // Zero delay fires on the first tick; the second loss hits the limit
    // and every further loss reports exhaustion again until a success.
    configure(1'b1, 8'd2, 16'd0, 16'd0, 1'b0);
    send_request(MODE_LINK_LOST, 1'b0);
    send_request(MODE_TICK, 1'b0);
    send_request(MODE_LINK_LOST, 1'b0);
    send_request(MODE_LINK_LOST, 1'b1);
    send_request(MODE_TICK, 1'b1);
    send_request(MODE_CONNECTING, 1'b1);
    send_request(MODE_CONNECTED, 1'b0);

    // Short delays that double into a small cap.
    configure(1'b1, 8'd4, 16'd1, 16'd6, 1'b0);
    run_random(350);

    // Auto reconnect off: losses never count.
    configure(1'b0, 8'd3, 16'd2, 16'd9, 1'b0);
    run_random(150);

    // Retry limit of zero with zero delays; junk written past the last
    // register. The long burst saturates the retry count.
    configure(1'b1, 8'd0, 16'd0, 16'd0, 1'b1);
    loss_burst(260);
    run_random(200);

    // Widest limit with a base of one: the shift grows past the cap and on
    // past the point where it is clamped outright.
    configure(1'b1, 8'd255, 16'd1, 16'hFFFF, 1'b0);
    loss_burst(50);
    run_random(200);

    // Largest delays with a limit of one.
    configure(1'b1, 8'd1, 16'hFFFF, 16'hFFFF, 1'b0);
    run_random(100);

    // Assorted settings, mostly small enough that the timer fires often.
    repeat (5) begin
      configure($urandom_range(0, 9) != 0,
                $urandom_range(0, 1) ? 8'($urandom_range(1, 8)) : 8'($urandom),
                ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 6)) : 16'($urandom),
                ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 40)) : 16'($urandom),
                $urandom_range(0, 1));
      run_random(100);
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Checked %0d requests under %0d register settings.",
             chk.num_results, n_settings + 1);
    $display("Saw %0d reconnect pulses and %0d retry-limit events.",
             chk.num_reconnects, chk.num_exhausted);
    if ((chk.num_errors == 0) && (chk.pending() == 0)) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lrbc_pkg.sv
sv/lrbc_backoff.sv
sv/link_reconnect_backoff_controller.sv
sv/lrbc_checker.sv
verif/reconnect_checker_pkg.sv
verif/tb_top.sv
